FILE: src/mlr_pkg.sv
package mlr_pkg;

  // Coordinate and decision widths
  localparam int COORD_BITS = 12;
  localparam int DEC_BITS   = COORD_BITS + 4;
  localparam int COLOR_BITS = 24;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_BITS  = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;
  typedef logic [COLOR_BITS-1:0]        color_t;

  // Request kinds carried in tuser
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_t;

  // Run state of the line in progress
  typedef struct packed {
    logic   active;
    coord_t cur_x;
    coord_t cur_y;
    coord_t major_end;
    dec_t   decision;
    dec_t   inc_minor;
    dec_t   inc_major;
    logic   steep;
    logic   falling;
    color_t color;
  } line_state_t;

  // One emitted pixel
  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

endpackage

FILE: src/mlr_setup.sv
module mlr_setup
  import mlr_pkg::*;
(
  input  coord_t      start_x,
  input  coord_t      start_y,
  input  coord_t      end_x,
  input  coord_t      end_y,
  input  color_t      line_color,
  output line_state_t load_state
);

  dec_t   dx_raw, dy_raw, adx, ady, dx, dy, dx2, dy2;
  logic   steep, swap, falling;
  coord_t ax, ay, bx, by;

  // Classify the line by comparing span magnitudes
  always_comb begin
    dx_raw = dec_t'(end_x) - dec_t'(start_x);
    dy_raw = dec_t'(end_y) - dec_t'(start_y);
    adx    = dx_raw[DEC_BITS-1] ? -dx_raw : dx_raw;
    ady    = dy_raw[DEC_BITS-1] ? -dy_raw : dy_raw;
    steep  = ady > adx;
    swap   = steep ? (start_y > end_y) : (start_x > end_x);
  end

  // Order endpoints so the major axis counts upward
  always_comb begin
    ax  = swap ? end_x   : start_x;
    ay  = swap ? end_y   : start_y;
    bx  = swap ? start_x : end_x;
    by  = swap ? start_y : end_y;
    dx  = dec_t'(bx) - dec_t'(ax);
    dy  = dec_t'(by) - dec_t'(ay);
    dx2 = dx <<< 1;
    dy2 = dy <<< 1;
    falling = steep ? dx[DEC_BITS-1] : dy[DEC_BITS-1];
  end

  // Load decision value and increments for the octant
  always_comb begin
    load_state.active  = 1'b1;
    load_state.cur_x   = ax;
    load_state.cur_y   = ay;
    load_state.steep   = steep;
    load_state.falling = falling;
    load_state.color   = line_color;
    if (!steep) begin
      load_state.major_end = bx;
      load_state.inc_major = -dy2;
      if (!falling) begin
        load_state.decision  = dx - dy2;
        load_state.inc_minor = dx2 - dy2;
      end else begin
        load_state.decision  = -dx - dy2;
        load_state.inc_minor = -dx2 - dy2;
      end
    end else begin
      load_state.major_end = by;
      load_state.inc_major = dx2;
      if (!falling) begin
        load_state.decision  = dx2 - dy;
        load_state.inc_minor = dx2 - dy2;
      end else begin
        load_state.decision  = dx2 + dy;
        load_state.inc_minor = dx2 + dy2;
      end
    end
  end

endmodule

FILE: src/mlr_step.sv
module mlr_step
  import mlr_pkg::*;
(
  input  line_state_t cur_state,
  output line_state_t next_state,
  output pixel_t      pixel
);

  coord_t major, minor_delta;
  logic   last, neg, zero, take;

  // Emit the current pixel and test for the end of the run
  always_comb begin
    major       = cur_state.steep ? cur_state.cur_y : cur_state.cur_x;
    last        = major >= cur_state.major_end;
    pixel.x     = cur_state.cur_x;
    pixel.y     = cur_state.cur_y;
    pixel.color = cur_state.color;
    pixel.last  = last;
  end

  // Pick the minor step from the decision sign
  always_comb begin
    neg  = cur_state.decision[DEC_BITS-1];
    zero = (cur_state.decision == '0);
    case ({cur_state.steep, cur_state.falling})
      2'b00:   take = neg;
      2'b01:   take = !neg;
      2'b10:   take = !neg && !zero;
      default: take = neg || zero;
    endcase
    minor_delta = cur_state.falling ? -coord_t'(1) : coord_t'(1);
  end

  // Advance major, maybe minor, and update decision; drop the run at its end
  always_comb begin
    next_state = cur_state;
    if (last) begin
      next_state.active = 1'b0;
    end else begin
      if (!cur_state.steep) begin
        next_state.cur_x = cur_state.cur_x + coord_t'(1);
        if (take) next_state.cur_y = cur_state.cur_y + minor_delta;
      end else begin
        next_state.cur_y = cur_state.cur_y + coord_t'(1);
        if (take) next_state.cur_x = cur_state.cur_x + minor_delta;
      end
      next_state.decision = cur_state.decision +
                            (take ? cur_state.inc_minor : cur_state.inc_major);
    end
  end

endmodule

FILE: src/midpoint_line_rasterizer.sv
// Channel | Dir | tdata (low bit up)                                  | tuser    | tlast
// in_     | in  | start_x, start_y, end_x, end_y, line_color           | req_type | -
// out_    | out | pixel_x, pixel_y, pixel_color                        | -        | last_pixel
//
// One request per clock unless out_tready stalls: a request sits in the input
// register, where the setup or step logic works on it and updates the run state,
// then a pixel lands in the output register.
// Load requests and steps with no active line produce no pixel.
// rst_n (synchronous) clears both stages and ends any run.
// A stall at out_tready holds a full input register, so in_tready falls in the same cycle.
module midpoint_line_rasterizer
  import mlr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // start_x, start_y, end_x, end_y, line_color
  input  logic                     in_tuser,   // req_type
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // pixel_x, pixel_y, pixel_color
  output logic                     out_tlast   // last_pixel
);

  localparam int SY = COORD_BITS;
  localparam int EX = 2 * COORD_BITS;
  localparam int EY = 3 * COORD_BITS;
  localparam int CL = 4 * COORD_BITS;

  logic        in_v_r, in_v_nxt;
  req_t        req_r;
  coord_t      sx_r, sy_r, ex_r, ey_r;
  color_t      color_r;
  line_state_t state_r, state_nxt, load_state, step_state;
  pixel_t      pix, pix_r;
  logic        out_v_r, out_v_nxt;
  logic        fire, emit;

  mlr_setup u_setup (
    .start_x    (sx_r),
    .start_y    (sy_r),
    .end_x      (ex_r),
    .end_y      (ey_r),
    .line_color (color_r),
    .load_state (load_state)
  );

  mlr_step u_step (
    .cur_state  (state_r),
    .next_state (step_state),
    .pixel      (pix)
  );

  // Handshake: work the held request when the output slot frees up
  always_comb begin
    fire      = in_v_r && (!out_v_r || out_tready);
    emit      = fire && (req_r == REQ_STEP) && state_r.active;
    in_tready = !in_v_r || fire;
    in_v_nxt  = in_tready ? in_tvalid : in_v_r;
    out_v_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  // Select the next run state
  always_comb begin
    state_nxt = state_r;
    if (fire) begin
      if (req_r == REQ_LOAD) state_nxt = load_state;
      else if (state_r.active) state_nxt = step_state;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      state_r <= state_nxt;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r   <= req_t'(in_tuser);
      sx_r    <= in_tdata[SY-1:0];
      sy_r    <= in_tdata[EX-1:SY];
      ex_r    <= in_tdata[EY-1:EX];
      ey_r    <= in_tdata[CL-1:EY];
      color_r <= in_tdata[CL+COLOR_BITS-1:CL];
    end
  end

  // Hold the pixel until taken
  always_ff @(posedge clk) begin
    if (emit) pix_r <= pix;
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = pix_r.last;
  assign out_tdata  = OUT_DATA_BITS'({pix_r.color, pix_r.y, pix_r.x});

endmodule

FILE: test/midpoint_line_rasterizer_tb.sv
module midpoint_line_rasterizer_tb;
  import mlr_pkg::*;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;   // start_x, start_y, end_x, end_y, line_color
  logic                     in_tuser;   // req_type
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;  // pixel_x, pixel_y, pixel_color
  logic                     out_tlast;  // last_pixel

  // Predicted run state, kept at the block's widths
  typedef struct {
    bit     active;
    coord_t x;
    coord_t y;
    coord_t major_end;
    dec_t   decision;
    dec_t   inc_minor;
    dec_t   inc_major;
    bit     steep;
    bit     falling;
    color_t color;
  } run_state_t;

  run_state_t line_run;
  pixel_t     pending_pixels[$];
  pixel_t     got_px;
  pixel_t     want_px;
  bit         calm;
  int         mismatches;
  int         useful_requests;
  int         loads_sent;
  int         pixels_checked;
  int         lines_closed;

  midpoint_line_rasterizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Apply one accepted request to the predicted run; queue the pixel it emits
  task automatic rasterize_request(input req_t kind, input coord_t ax, input coord_t ay,
                                   input coord_t bx, input coord_t by, input color_t color);
    int     dx;
    int     dy;
    coord_t t;
    coord_t major;
    bit     steep;
    bit     last;
    bit     take;
    if (kind == REQ_LOAD) begin
      steep = mag(int'(by) - int'(ay)) > mag(int'(bx) - int'(ax));
      // order endpoints so the major axis counts up
      if ((!steep && ax > bx) || (steep && ay > by)) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      dx = int'(bx) - int'(ax);
      dy = int'(by) - int'(ay);
      line_run.steep = steep;
      if (!steep) begin
        line_run.falling   = dy < 0;
        line_run.major_end = bx;
        line_run.inc_major = dec_t'(-2 * dy);
        if (dy >= 0) begin
          line_run.decision  = dec_t'(dx - 2 * dy);
          line_run.inc_minor = dec_t'(2 * dx - 2 * dy);
        end else begin
          line_run.decision  = dec_t'(-dx - 2 * dy);
          line_run.inc_minor = dec_t'(-2 * dx - 2 * dy);
        end
      end else begin
        line_run.falling   = dx < 0;
        line_run.major_end = by;
        line_run.inc_major = dec_t'(2 * dx);
        if (dx >= 0) begin
          line_run.decision  = dec_t'(2 * dx - dy);
          line_run.inc_minor = dec_t'(2 * dx - 2 * dy);
        end else begin
          line_run.decision  = dec_t'(2 * dx + dy);
          line_run.inc_minor = dec_t'(2 * dx + 2 * dy);
        end
      end
      line_run.x      = ax;
      line_run.y      = ay;
      line_run.color  = color;
      line_run.active = 1'b1;
      loads_sent++;
      useful_requests++;
    end else if (line_run.active) begin
      major = line_run.steep ? line_run.y : line_run.x;
      last  = major >= line_run.major_end;
      pending_pixels.push_back('{x: line_run.x, y: line_run.y,
                                 color: line_run.color, last: last});
      useful_requests++;
      if (last) begin
        line_run.active = 1'b0;
      end else begin
        if (!line_run.steep)
          take = line_run.falling ? (line_run.decision >= 0) : (line_run.decision < 0);
        else
          take = line_run.falling ? (line_run.decision <= 0) : (line_run.decision > 0);
        // advance the major axis, step the minor one when the decision says so
        if (!line_run.steep) begin
          line_run.x = line_run.x + coord_t'(1);
          if (take)
            line_run.y = line_run.falling ? line_run.y - coord_t'(1) : line_run.y + coord_t'(1);
        end else begin
          line_run.y = line_run.y + coord_t'(1);
          if (take)
            line_run.x = line_run.falling ? line_run.x - coord_t'(1) : line_run.x + coord_t'(1);
        end
        line_run.decision = line_run.decision +
                            (take ? line_run.inc_minor : line_run.inc_major);
      end
    end
  endtask

  // Send one request; called and returns at a falling edge
  task automatic push_request(input req_t kind, input coord_t sx, input coord_t sy,
                              input coord_t ex, input coord_t ey, input color_t color);
    while (!calm && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {color, ey, ex, sy, sx};
    do @(posedge clk); while (!in_tready);
    rasterize_request(kind, sx, sy, ex, ey, color);
    @(negedge clk);
  endtask

  // Load a line, then step it to its end or until max_steps steps were sent
  task automatic draw_line(input coord_t sx, input coord_t sy, input coord_t ex,
                           input coord_t ey, input color_t color, input int max_steps);
    int n;
    n = 0;
    push_request(REQ_LOAD, sx, sy, ex, ey, color);
    while (line_run.active && n != max_steps) begin
      push_request(REQ_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                   coord_t'($urandom), color_t'($urandom));
      n++;
    end
  endtask

  // A step request before any line was loaded
  task automatic test_no_line();
    push_request(REQ_STEP, coord_t'(5), coord_t'(-5), coord_t'(7), coord_t'(-7), 24'h123456);
  endtask

  // Shallow and steep, rising and falling, with and without endpoint swap
  task automatic test_octants();
    draw_line(coord_t'(2), coord_t'(1), coord_t'(0), coord_t'(0), 24'h0000ff, -1);
    draw_line(coord_t'(0), coord_t'(0), coord_t'(2), coord_t'(-1), 24'h00ff00, -1);
    draw_line(coord_t'(7), coord_t'(7), coord_t'(8), coord_t'(9), 24'hff0000, -1);
    draw_line(coord_t'(-6), coord_t'(2), coord_t'(-5), coord_t'(0), 24'h5a5a5a, -1);
  endtask

  // Vertical line, then a step after the run has ended
  task automatic test_vertical();
    draw_line(coord_t'(100), coord_t'(-3), coord_t'(100), coord_t'(-2), 24'ha5a5a5, -1);
    push_request(REQ_STEP, '1, '1, '1, '1, '1);
  endtask

  // Full-range diagonal cut short by a reload to a single point at a corner
  task automatic test_extremes();
    draw_line(coord_t'(2047), coord_t'(2047), coord_t'(-2048), coord_t'(-2048),
              24'hffffff, 2);
    draw_line(coord_t'(-2048), coord_t'(2047), coord_t'(-2048), coord_t'(2047),
              24'h000000, -1);
  endtask

  // Mostly whole lines with random content, some cut short, some noise requests
  task automatic test_random_lines(input int count);
    int first;
    int len;
    int dmaj;
    int dmin;
    int dx;
    int dy;
    int sx;
    int sy;
    first = useful_requests;
    while (useful_requests - first < count) begin
      calm = (useful_requests - first >= 350) && (useful_requests - first < 500);
      if ($urandom_range(99) < 12) begin
        push_request(req_t'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom),
                     coord_t'($urandom), coord_t'($urandom), color_t'($urandom));
      end else begin
        len  = ($urandom_range(29) == 0) ? $urandom_range(300) : $urandom_range(15);
        dmaj = $urandom_range(1) ? len : -len;
        dmin = $urandom_range(2 * len) - len;
        if ($urandom_range(1)) begin
          dx = dmaj; dy = dmin;
        end else begin
          dx = dmin; dy = dmaj;
        end
        // keep both endpoints inside the coordinate range
        sx = -2048 + ((dx < 0) ? -dx : 0) + $urandom_range(4095 - mag(dx));
        sy = -2048 + ((dy < 0) ? -dy : 0) + $urandom_range(4095 - mag(dy));
        draw_line(coord_t'(sx), coord_t'(sy), coord_t'(sx + dx), coord_t'(sy + dy),
                  color_t'($urandom), ($urandom_range(19) == 0) ? $urandom_range(len) : -1);
        if ($urandom_range(9) == 0)
          push_request(REQ_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                       coord_t'($urandom), color_t'($urandom));
      end
    end
    calm = 1'b0;
  endtask

  // Stall the result side at random
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 14);
  end

  // Compare each accepted pixel with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_px.x     = coord_t'(out_tdata[COORD_BITS-1:0]);
      got_px.y     = coord_t'(out_tdata[2*COORD_BITS-1:COORD_BITS]);
      got_px.color = color_t'(out_tdata[2*COORD_BITS+COLOR_BITS-1:2*COORD_BITS]);
      got_px.last  = out_tlast;
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d", got_px.x, got_px.y);
        mismatches++;
      end else begin
        want_px = pending_pixels.pop_front();
        pixels_checked++;
        if (want_px.last)
          lines_closed++;
        if (got_px.x !== want_px.x) begin
          $error("pixel_x expected %0d got %0d", want_px.x, got_px.x);
          mismatches++;
        end
        if (got_px.y !== want_px.y) begin
          $error("pixel_y expected %0d got %0d", want_px.y, got_px.y);
          mismatches++;
        end
        if (got_px.color !== want_px.color) begin
          $error("pixel_color expected %06h got %06h", want_px.color, got_px.color);
          mismatches++;
        end
        if (got_px.last !== want_px.last) begin
          $error("last_pixel expected %0b got %0b", want_px.last, got_px.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_LOAD;
    out_tready = 1'b0;
    calm       = 1'b0;
    line_run   = '{default: '0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_no_line();
    test_octants();
    test_vertical();
    test_extremes();
    test_random_lines(900);
    in_tvalid <= 1'b0;

    // Drain, then watch for stray pixels
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d line loads and %0d pixels over %0d completed lines,",
             loads_sent, pixels_checked, lines_closed);
    $display("all octants, endpoint swaps, reloads mid-line and idle step requests.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/mlr_pkg.sv
src/mlr_setup.sv
src/mlr_step.sv
src/midpoint_line_rasterizer.sv
test/midpoint_line_rasterizer_tb.sv
